// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the base64 line-wrapped encoder.
// No dependencies; expects signals clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while in reset.
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising clock edge, also during reset.
`define AST_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/b64lw_pkg.sv -----
// Package for the base64 line-wrapped encoder: character constants, line
// length and the 6-bit to alphabet mapping. No dependencies.
package b64lw_pkg;

  // Bytes of message per output line before CR LF (3 to 63).
  localparam int BYTES_PER_LINE = 57;
  localparam int LINE_CNT_W     = 6;

  // Characters one input item can produce: a full group plus CR LF.
  localparam int MAX_CHARS = 6;
  localparam int CHAR_CNT_W = 3;

  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_PAD = 8'h3d;

  // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] ch;
    if (v < 6'd26) begin
      ch = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      ch = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      ch = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      ch = 8'h2b;
    end else begin
      ch = 8'h2f;
    end
    return ch;
  endfunction

endpackage

// ----- rtl/base64_line_wrapped_encoder_core.sv -----
// Top level of the base64 line-wrapped encoder (MIME style, CR LF wrap).
// Depends on b64lw_pkg and assert_macros.svh.
//
// Takes one message byte per item on the in_ stream, in_tlast marking the
// final byte of a message, and streams the encoded ASCII characters one per
// cycle on the out_ stream while out_tready is high. A byte that yields
// characters is accepted whenever the character buffer is empty or is
// handing over its last character in that same cycle; bytes that only fill
// the group buffer leave it untouched and are taken in any cycle. A group of
// three bytes yields four characters, or six when a line of BYTES_PER_LINE
// bytes closes with CR LF, so the single-character output port sets the
// sustained byte rate. out_tuser marks the last character caused by an
// input byte, out_tlast the last character of the encoded message.
// State clears after each final byte.
`include "assert_macros.svh"

module base64_line_wrapped_encoder_core
  import b64lw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // final_byte
  // output stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tuser,  // run_end
  output logic       out_tlast   // message_end
);

  // group buffer and line position
  logic [15:0]           pend_bytes_r, pend_bytes_nxt;
  logic [1:0]            pend_cnt_r, pend_cnt_nxt;
  logic [LINE_CNT_W-1:0] lc_r, lc_nxt;

  // character buffer, drained from entry 0
  logic [7:0]            buf_r [MAX_CHARS];
  logic [7:0]            buf_nxt [MAX_CHARS];
  logic [CHAR_CNT_W-1:0] rem_r, rem_nxt;
  logic                  fin_r, fin_nxt;

  logic                  in_fire, out_fire;
  logic [7:0]            grp [MAX_CHARS];
  logic [CHAR_CNT_W-1:0] grp_n;
  logic [LINE_CNT_W-1:0] lc_inc, lc_step;
  logic [7:0]            b0, b1, b;

  assign out_tvalid = (rem_r != '0);
  assign out_tdata  = buf_r[0];
  assign out_tuser  = (rem_r == CHAR_CNT_W'(1));
  assign out_tlast  = out_tuser & fin_r;
  assign out_fire   = out_tvalid & out_tready;
  // fill-only bytes never touch the character buffer
  assign in_tready  = (rem_r == '0) || ((rem_r == CHAR_CNT_W'(1)) && out_tready) ||
                      (!pend_cnt_r[1] && !in_tlast);
  assign in_fire    = in_tvalid & in_tready;

  // encode one byte against the held group
  always_comb begin
    b       = in_tdata;
    lc_inc  = lc_r + LINE_CNT_W'(1);
    lc_step = (lc_inc == LINE_CNT_W'(BYTES_PER_LINE)) ? '0 : lc_inc;
    b0      = pend_bytes_r[15:8];
    b1      = pend_bytes_r[7:0];
    for (int k = 0; k < MAX_CHARS; k++) begin
      grp[k] = CH_PAD;
    end
    grp_n          = '0;
    pend_bytes_nxt = pend_bytes_r;
    pend_cnt_nxt   = pend_cnt_r;
    lc_nxt         = lc_step;

    if (pend_cnt_r[1]) begin
      // group of three complete (a count of 3 acts as 2)
      grp[0] = b64_sym(b0[7:2]);
      grp[1] = b64_sym({b0[1:0], b1[7:4]});
      grp[2] = b64_sym({b1[3:0], b[7:6]});
      grp[3] = b64_sym(b[5:0]);
      grp[4] = CH_CR;
      grp[5] = CH_LF;
      grp_n  = (lc_step == '0) ? CHAR_CNT_W'(6) : CHAR_CNT_W'(4);
      pend_bytes_nxt = '0;
      pend_cnt_nxt   = '0;
    end else if (in_tlast && pend_cnt_r[0]) begin
      // two-byte final group
      grp[0] = b64_sym(b1[7:2]);
      grp[1] = b64_sym({b1[1:0], b[7:4]});
      grp[2] = b64_sym({b[3:0], 2'b00});
      grp_n  = CHAR_CNT_W'(4);
    end else if (in_tlast) begin
      // one-byte final group
      grp[0] = b64_sym(b[7:2]);
      grp[1] = b64_sym({b[1:0], 4'b0000});
      grp_n  = CHAR_CNT_W'(4);
    end else begin
      pend_bytes_nxt = {b1, b};
      pend_cnt_nxt   = pend_cnt_r + 2'd1;
    end

    // message done: clear for the next one
    if (in_tlast) begin
      pend_bytes_nxt = '0;
      pend_cnt_nxt   = '0;
      lc_nxt         = '0;
    end
  end

  // character buffer: shift on take, load on an item that produces output
  always_comb begin
    for (int k = 0; k < MAX_CHARS; k++) begin
      buf_nxt[k] = buf_r[k];
    end
    rem_nxt = rem_r;
    fin_nxt = fin_r;
    if (out_fire) begin
      for (int k = 0; k < MAX_CHARS - 1; k++) begin
        buf_nxt[k] = buf_r[k + 1];
      end
      rem_nxt = rem_r - CHAR_CNT_W'(1);
    end
    if (in_fire && (grp_n != '0)) begin
      for (int k = 0; k < MAX_CHARS; k++) begin
        buf_nxt[k] = grp[k];
      end
      rem_nxt = grp_n;
      fin_nxt = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bytes_r <= '0;
      pend_cnt_r   <= '0;
      lc_r         <= '0;
      rem_r        <= '0;
      fin_r        <= 1'b0;
    end else begin
      if (in_fire) begin
        pend_bytes_r <= pend_bytes_nxt;
        pend_cnt_r   <= pend_cnt_nxt;
        lc_r         <= lc_nxt;
      end
      rem_r <= rem_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_CHARS; k++) begin
      buf_r[k] <= buf_nxt[k];
    end
  end

  // checks
  `AST_CLK(a_no_overwrite, (in_fire && grp_n != '0) |-> (rem_r == '0) || (out_fire && rem_r == CHAR_CNT_W'(1)), "item accepted over undelivered characters")
  `AST_CLK(a_rem_range, rem_r <= CHAR_CNT_W'(MAX_CHARS), "character count out of range")
  `AST_CLK(a_pend_range, pend_cnt_r != 2'd3, "group buffer holds three bytes")
  `AST_CLK(a_msg_clear, (in_fire && in_tlast) |=> (pend_cnt_r == '0) && (lc_r == '0), "state not cleared after final byte")

endmodule
